@@ rtl/dam_pkg.sv @@
// dam_pkg: shared types and codes of the accumulator modify unit
// holds the request layout, flag word, operation, condition and status codes
// no dependencies
package dam_pkg;

	localparam int unsigned AccW = 36;

	typedef enum logic [1:0] {
		KIND_MODIFY     = 2'd0,
		KIND_LOAD_ACC   = 2'd1,
		KIND_LOAD_FLAGS = 2'd2,
		KIND_UNUSED     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_SHR  = 4'd0,
		OP_SHR4 = 4'd1,
		OP_SHL  = 4'd2,
		OP_SHL4 = 4'd3,
		OP_ROR  = 4'd4,
		OP_ROL  = 4'd5,
		OP_CLR  = 4'd6,
		OP_RSV  = 4'd7,
		OP_NOT  = 4'd8,
		OP_NEG  = 4'd9,
		OP_RND  = 4'd10,
		OP_PACR = 4'd11,
		OP_CLRR = 4'd12,
		OP_INC  = 4'd13,
		OP_DEC  = 4'd14,
		OP_COPY = 4'd15
	} op_t;

	typedef enum logic [3:0] {
		CC_TRUE = 4'd0,
		CC_EQ   = 4'd1,
		CC_NE   = 4'd2,
		CC_GT   = 4'd3,
		CC_GE   = 4'd4,
		CC_LT   = 4'd5,
		CC_LE   = 4'd6,
		CC_NN   = 4'd7,
		CC_V    = 4'd8,
		CC_C    = 4'd9,
		CC_E    = 4'd10,
		CC_L    = 4'd11,
		CC_T12  = 4'd12,
		CC_T13  = 4'd13,
		CC_T14  = 4'd14,
		CC_T15  = 4'd15
	} cond_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_SKIPPED  = 2'd1,
		ST_RESERVED = 2'd2,
		ST_NOP      = 2'd3
	} status_t;

	// zero flag in the lowest bit, limit in the highest
	typedef struct packed {
		logic l;
		logic e;
		logic c;
		logic v;
		logic n;
		logic m;
		logic z;
	} flags_t;

	typedef struct packed {
		kind_t            kind;
		logic [AccW-1:0]  load_value;
		logic             acc_select;
		cond_t            cond_code;
		op_t              op_code;
	} item_t;

	typedef struct packed {
		logic            acc_wr;
		logic [AccW-1:0] acc_value;
		flags_t          flags;
		status_t         status;
	} upd_t;

endpackage

@@ rtl/dam_exec.sv @@
// dam_exec: condition check, accumulator operation and flag update for one request
// uses dam_pkg; purely combinational, sits between the request and result registers
module dam_exec (
	input  dam_pkg::item_t              item,
	input  logic [dam_pkg::AccW-1:0]    acc0,
	input  logic [dam_pkg::AccW-1:0]    acc1,
	input  dam_pkg::flags_t             flags,
	input  logic                        arith,
	output dam_pkg::upd_t               upd
);
	import dam_pkg::*;

	logic [AccW-1:0] a;
	logic [AccW-1:0] res;
	logic            cond_ok;
	logic            chg;
	logic            fill;
	logic            c_new;
	logic            v_new;
	logic            e_new;
	logic            z_new;

	assign a    = item.acc_select ? acc1 : acc0;
	assign fill = arith & a[AccW-1];

	always_comb begin
		case (item.cond_code)
			CC_EQ:   cond_ok = flags.z;
			CC_NE:   cond_ok = !flags.z;
			CC_GT:   cond_ok = !flags.m && !flags.z;
			CC_GE:   cond_ok = !flags.m;
			CC_LT:   cond_ok = flags.m;
			CC_LE:   cond_ok = flags.m || flags.z;
			CC_NN:   cond_ok = !flags.n;
			CC_V:    cond_ok = flags.v;
			CC_C:    cond_ok = flags.c;
			CC_E:    cond_ok = flags.e;
			CC_L:    cond_ok = flags.l;
			default: cond_ok = 1'b1;
		endcase
	end

	// operation result with carry and overflow side effects
	always_comb begin
		res   = a;
		chg   = 1'b1;
		c_new = flags.c;
		v_new = flags.v;
		case (item.op_code)
			OP_SHR: begin
				c_new = a[0];
				v_new = 1'b0;
				res   = {fill, a[AccW-1:1]};
			end
			OP_SHR4: begin
				c_new = a[3];
				v_new = 1'b0;
				res   = {{4{fill}}, a[AccW-1:4]};
			end
			OP_SHL: begin
				c_new = a[AccW-1];
				res   = {a[AccW-2:0], 1'b0};
			end
			OP_SHL4: begin
				c_new = a[32];
				res   = {a[AccW-5:0], 4'd0};
			end
			OP_CLR:  res = '0;
			OP_NOT:  res = ~a;
			OP_NEG:  res = (~a) + AccW'(1);
			OP_CLRR: res = AccW'(16'h8000);
			OP_INC:  res = a + AccW'(1);
			OP_DEC:  res = a - AccW'(1);
			OP_COPY: res = a;
			default: chg = 1'b0;
		endcase
	end

	assign e_new = !((res[AccW-1:32] == 4'h0) || (res[AccW-1:32] == 4'hF));
	assign z_new = (res == '0);

	always_comb begin
		upd.acc_wr    = 1'b0;
		upd.acc_value = a;
		upd.flags     = flags;
		upd.status    = ST_DONE;
		case (item.kind)
			KIND_MODIFY: begin
				if (!cond_ok) begin
					upd.status = ST_SKIPPED;
				end else if (chg) begin
					upd.acc_wr    = 1'b1;
					upd.acc_value = res;
					upd.flags.c   = c_new;
					upd.flags.v   = v_new;
					upd.flags.e   = e_new;
					upd.flags.z   = z_new;
					upd.flags.m   = res[AccW-1];
					upd.flags.n   = z_new || (!e_new && (res[31] == res[30]));
				end else if (item.op_code == OP_RSV) begin
					upd.status = ST_RESERVED;
				end else begin
					upd.status = ST_NOP;
				end
			end
			KIND_LOAD_ACC: begin
				upd.acc_wr    = 1'b1;
				upd.acc_value = item.load_value;
			end
			KIND_LOAD_FLAGS: begin
				upd.flags = flags_t'(item.load_value[6:0]);
			end
			default: upd.status = ST_NOP;
		endcase
	end

endmodule

@@ rtl/dsp_accumulator_modify_unit_core.sv @@
// dsp_accumulator_modify_unit_core: top level of the accumulator modify unit
// uses dam_pkg and dam_exec; holds the request, result and architectural state registers
//
// Requests come in on the s_* stream: s_tuser carries the kind (modify,
// load accumulator, load flags), s_tdata the operation, condition, accumulator
// select and load value. Every request yields exactly one result on the m_*
// stream: the selected accumulator after the request, all seven flags and a
// status code (done, condition false, reserved op, no-op).
// cfg_valid/cfg_data write the right-shift mode bit; cfg_ready is always high,
// and the bit should only change while no request is in flight.
// A request is held in the request register, then the operation and the state
// update happen together as it moves into the result register. One request per
// cycle is sustained while the receiver keeps m_tready high, since the state
// written by one request is visible to the next at the same clock edge.
// Reset clears both accumulators, the flags and the shift mode and empties
// both registers. When the receiver holds m_tready low the result stays put,
// one more request is buffered in the request register, and s_tready drops.
module dsp_accumulator_modify_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op_code[3:0], cond_code[7:4], acc_select[8], load_value[44:9], zero fill
	input  logic [47:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// acc_value[35:0], flag_zero, flag_minus, flag_normal, flag_overflow,
	// flag_carry, flag_extension, flag_limit [42:36], zero fill
	output logic [47:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import dam_pkg::*;

	item_t           item_in;
	item_t           item_s1;
	logic            valid_s1;
	logic            valid_s2;
	logic [AccW-1:0] acc_s2;
	flags_t          flags_s2;
	status_t         status_s2;
	logic [AccW-1:0] acc0_q;
	logic [AccW-1:0] acc1_q;
	flags_t          flags_q;
	logic            arith_q;
	logic            adv;
	logic            out_free;
	upd_t            upd;

	assign item_in.kind       = kind_t'(s_tuser);
	assign item_in.op_code    = op_t'(s_tdata[3:0]);
	assign item_in.cond_code  = cond_t'(s_tdata[7:4]);
	assign item_in.acc_select = s_tdata[8];
	assign item_in.load_value = s_tdata[44:9];

	assign out_free  = !valid_s2 || m_tready;
	assign adv       = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	dam_exec u_exec (
		.item  (item_s1),
		.acc0  (acc0_q),
		.acc1  (acc1_q),
		.flags (flags_q),
		.arith (arith_q),
		.upd   (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc0_q   <= '0;
			acc1_q   <= '0;
			flags_q  <= '0;
			arith_q  <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				flags_q <= upd.flags;
				if (upd.acc_wr && !item_s1.acc_select) begin
					acc0_q <= upd.acc_value;
				end
				if (upd.acc_wr && item_s1.acc_select) begin
					acc1_q <= upd.acc_value;
				end
			end
			if (cfg_valid) begin
				arith_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
		if (adv) begin
			acc_s2    <= upd.acc_value;
			flags_s2  <= upd.flags;
			status_s2 <= upd.status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, flags_s2, acc_s2};
	assign m_tuser  = status_s2;

	// a skipped request leaves the flags alone
	a_skip_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && upd.status == ST_SKIPPED) |=> $stable(flags_q))
		else $error("flags changed on a skipped request");

	// modify requests never touch the limit flag
	a_modify_keeps_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.kind == KIND_MODIFY) |=> (flags_q.l == $past(flags_q.l)))
		else $error("limit flag changed by a modify request");

	// result register shows the state that the request left behind
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (flags_s2 == flags_q) &&
			(acc_s2 == ($past(item_s1.acc_select) ? acc1_q : acc0_q)))
		else $error("result does not match architectural state");

	// a flags load lands in the flag register
	a_flag_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.kind == KIND_LOAD_FLAGS) |=>
			(flags_q == flags_t'($past(item_s1.load_value[6:0]))))
		else $error("flags load lost");

	// the request side only stalls behind a held request
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("request side stalled without cause");

endmodule
